@@ rtl/core/chroma_key_alpha_spill_defines.svh @@
// ---------------------------------------------------------------------------
// chroma key assertion macros
// concurrent assertion helpers for the chroma keyer, sampled on clk_i and
// disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef CHROMA_KEY_ALPHA_SPILL_DEFINES_SVH
`define CHROMA_KEY_ALPHA_SPILL_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CKAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CKAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ckas_pkg.sv @@
// ---------------------------------------------------------------------------
// chroma key package
// shared widths, register codes, reset values and pipeline stage numbers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckas_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SqW      = 2 * ChanW;
  localparam int unsigned SumW     = SqW + 2;
  localparam int unsigned ThrW     = 36;
  localparam int unsigned ScaleW   = 18;
  localparam int unsigned WeightW  = FracW + FracW + 1;

  // 3 * 255 * 255, the largest squared rgb distance
  localparam logic [ScaleW-1:0] MaxDist = ScaleW'(3 * 255 * 255);
  localparam logic [FracW-1:0] SmoothMin = FracW'(66);

  localparam logic [ChanW-1:0] KeyBlueRst  = ChanW'(0);
  localparam logic [ChanW-1:0] KeyGreenRst = ChanW'(255);
  localparam logic [ChanW-1:0] KeyRedRst   = ChanW'(0);
  localparam logic [FracW-1:0] SimRst      = FracW'(26214);
  localparam logic [FracW-1:0] SmoothRst   = FracW'(6554);
  localparam logic [FracW-1:0] SpillRst    = FracW'(0);

  localparam longint unsigned SimRstL  = 64'(SimRst);
  localparam longint unsigned OuterRstL = 64'(SimRst) + 64'(SmoothRst);
  localparam logic [ThrW-1:0] ThrInRst =
    ThrW'((SimRstL * SimRstL * 64'(MaxDist) + 64'd32768) >> 16);
  localparam logic [ThrW-1:0] ThrOutRst =
    ThrW'((OuterRstL * OuterRstL * 64'(MaxDist) + 64'd32768) >> 16);
  localparam logic [ThrW-1:0] ThrDiffRst = ThrOutRst - ThrInRst;

  // divider: quotient bits resolved per pipeline stage
  localparam int unsigned DivBits   = 2;
  localparam int unsigned DivStages = FracW / DivBits;

  // pipeline stage numbers
  localparam int unsigned StgSq      = 1;
  localparam int unsigned StgCmp     = 2;
  localparam int unsigned StgDivLast = StgCmp + DivStages;
  localparam int unsigned StgSpill   = StgDivLast + 1;
  localparam int unsigned StgMag     = StgSpill + 1;
  localparam int unsigned StgOut     = StgMag + 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_BLUE   = 3'd0,
    REG_KEY_GREEN  = 3'd1,
    REG_KEY_RED    = 3'd2,
    REG_SIMILARITY = 3'd3,
    REG_SMOOTHNESS = 3'd4,
    REG_SPILL      = 3'd5
  } cfg_reg_e;

  // pixel sideband that travels down the pipeline
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic             eof;
    logic             ramp;
    logic             opaque;
  } pix_t;

endpackage

@@ rtl/core/chroma_key_alpha_spill.sv @@
// ---------------------------------------------------------------------------
// chroma keyer with green spill suppression
// per-pixel key alpha from squared rgb distance, linear ramp and spill fix
// ---------------------------------------------------------------------------
// usage
//   input channel: one bgr pixel plus end-of-frame flag per request,
//   in_valid_i / in_ready_o. output channel: bgr, alpha and the flag,
//   out_valid_o / out_ready_i, with every output driven from a register.
//   one pixel per clock is taken while the output side keeps taking
//   results and no threshold reload is running. each pixel passes
//   through the 13-stage pipeline in order: squares, threshold compare,
//   eight radix-4 divider stages, spill weight, spill product, output.
//   when the receiver stalls the whole pipeline holds and in_ready_o drops
//   in the same cycle; nothing is lost or repeated.
//   a write of similarity or smoothness reloads the thresholds through a
//   shared sequencer (square, scale, ramp width): in_ready_o stays low
//   while it runs. other registers take effect at once.
//   reset loads the default key (pure green) and the default thresholds,
//   and empties the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chroma_key_alpha_spill_defines.svh"

module chroma_key_alpha_spill (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [ckas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ckas_pkg::CfgDataW-1:0]  cfg_data_i,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ckas_pkg::ChanW-1:0]     blue_in_i,
  input  logic [ckas_pkg::ChanW-1:0]     green_in_i,
  input  logic [ckas_pkg::ChanW-1:0]     red_in_i,
  input  logic                           end_of_frame_i,
  // pixel output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ckas_pkg::ChanW-1:0]     blue_out_o,
  output logic [ckas_pkg::ChanW-1:0]     green_out_o,
  output logic [ckas_pkg::ChanW-1:0]     red_out_o,
  output logic [ckas_pkg::ChanW-1:0]     alpha_out_o,
  output logic                           frame_end_out_o
);

  typedef enum logic [1:0] {
    THR_IDLE,
    THR_SQUARE,
    THR_SCALE,
    THR_DIFF
  } thr_state_e;

  // -------------------------------------------------------------------------
  // configuration registers
  // -------------------------------------------------------------------------
  logic [ckas_pkg::ChanW-1:0] key_blue_q, key_green_q, key_red_q;
  logic [ckas_pkg::FracW-1:0] sim_q, smooth_q, spill_q;
  logic                       thr_reload;

  assign thr_reload = cfg_we_i &&
                      (cfg_idx_i == ckas_pkg::REG_SIMILARITY ||
                       cfg_idx_i == ckas_pkg::REG_SMOOTHNESS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_blue_q  <= ckas_pkg::KeyBlueRst;
      key_green_q <= ckas_pkg::KeyGreenRst;
      key_red_q   <= ckas_pkg::KeyRedRst;
      sim_q       <= ckas_pkg::SimRst;
      smooth_q    <= ckas_pkg::SmoothRst;
      spill_q     <= ckas_pkg::SpillRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ckas_pkg::REG_KEY_BLUE:   key_blue_q  <= cfg_data_i[ckas_pkg::ChanW-1:0];
        ckas_pkg::REG_KEY_GREEN:  key_green_q <= cfg_data_i[ckas_pkg::ChanW-1:0];
        ckas_pkg::REG_KEY_RED:    key_red_q   <= cfg_data_i[ckas_pkg::ChanW-1:0];
        ckas_pkg::REG_SIMILARITY: sim_q       <= cfg_data_i;
        // smoothness saturates at its floor so the ramp never collapses
        ckas_pkg::REG_SMOOTHNESS: smooth_q    <= (cfg_data_i < ckas_pkg::SmoothMin) ?
                                                 ckas_pkg::SmoothMin : cfg_data_i;
        ckas_pkg::REG_SPILL:      spill_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // threshold sequencer
  // square the radii, scale by the max distance, then form the ramp width
  // -------------------------------------------------------------------------
  thr_state_e                  thr_state_q;
  logic [31:0]                 sq_in_q;
  logic [33:0]                 sq_out_q;
  logic [ckas_pkg::ThrW-1:0]   thr_in_q, thr_out_q, thr_diff_q;
  logic [16:0]                 outer_r;
  logic [49:0]                 scale_in;
  logic [51:0]                 scale_out;

  assign outer_r   = 17'(sim_q) + 17'(smooth_q);
  assign scale_in  = 50'(sq_in_q) * 50'(ckas_pkg::MaxDist) + 50'd32768;
  assign scale_out = 52'(sq_out_q) * 52'(ckas_pkg::MaxDist) + 52'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_state_q <= THR_IDLE;
      sq_in_q     <= '0;
      sq_out_q    <= '0;
      thr_in_q    <= ckas_pkg::ThrInRst;
      thr_out_q   <= ckas_pkg::ThrOutRst;
      thr_diff_q  <= ckas_pkg::ThrDiffRst;
    end else if (thr_reload) begin
      // a new radius restarts the sequence with the latest values
      thr_state_q <= THR_SQUARE;
    end else begin
      case (thr_state_q)
        THR_IDLE: ;
        THR_SQUARE: begin
          sq_in_q     <= 32'(sim_q) * 32'(sim_q);
          sq_out_q    <= 34'(outer_r) * 34'(outer_r);
          thr_state_q <= THR_SCALE;
        end
        THR_SCALE: begin
          thr_in_q    <= ckas_pkg::ThrW'(scale_in[49:16]);
          thr_out_q   <= scale_out[51:16];
          thr_state_q <= THR_DIFF;
        end
        THR_DIFF: begin
          thr_diff_q  <= thr_out_q - thr_in_q;
          thr_state_q <= THR_IDLE;
        end
        default: thr_state_q <= THR_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // pipeline control: one enable, valid bits shift with the data
  // -------------------------------------------------------------------------
  logic                        en;
  logic                        in_fire;
  logic [ckas_pkg::StgOut:1]   v_q;
  ckas_pkg::pix_t              pix_q [1:ckas_pkg::StgOut];

  assign en         = !v_q[ckas_pkg::StgOut] || out_ready_i;
  assign in_ready_o = en && (thr_state_q == THR_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[ckas_pkg::StgOut-1:1], in_fire};
    end
  end

  // pass-through sideband for the later stages
  for (genvar s = ckas_pkg::StgCmp + 1; s <= ckas_pkg::StgOut; s++) begin : g_pass
    always_ff @(posedge clk_i) begin
      if (en) begin
        pix_q[s] <= pix_q[s-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage 1: per-channel squared distance to the key
  // -------------------------------------------------------------------------
  logic [ckas_pkg::ChanW-1:0] d_blue, d_green, d_red;
  logic [ckas_pkg::SqW-1:0]   sq_blue_q, sq_green_q, sq_red_q;

  assign d_blue  = (blue_in_i  > key_blue_q)  ? blue_in_i  - key_blue_q  : key_blue_q  - blue_in_i;
  assign d_green = (green_in_i > key_green_q) ? green_in_i - key_green_q : key_green_q - green_in_i;
  assign d_red   = (red_in_i   > key_red_q)   ? red_in_i   - key_red_q   : key_red_q   - red_in_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_blue_q               <= ckas_pkg::SqW'(d_blue)  * ckas_pkg::SqW'(d_blue);
      sq_green_q              <= ckas_pkg::SqW'(d_green) * ckas_pkg::SqW'(d_green);
      sq_red_q                <= ckas_pkg::SqW'(d_red)   * ckas_pkg::SqW'(d_red);
      pix_q[ckas_pkg::StgSq].blue   <= blue_in_i;
      pix_q[ckas_pkg::StgSq].green  <= green_in_i;
      pix_q[ckas_pkg::StgSq].red    <= red_in_i;
      pix_q[ckas_pkg::StgSq].eof    <= end_of_frame_i;
      pix_q[ckas_pkg::StgSq].ramp   <= 1'b0;
      pix_q[ckas_pkg::StgSq].opaque <= 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // stage 2: distance in q.16, compare against both thresholds
  // -------------------------------------------------------------------------
  logic [ckas_pkg::SumW-1:0]  dist_sum;
  logic [ckas_pkg::ThrW-1:0]  dist_fx;
  logic                       at_inner, at_outer;
  logic [ckas_pkg::ThrW-1:0]  rem_q [0:ckas_pkg::DivStages];
  logic [ckas_pkg::FracW-1:0] quo_q [0:ckas_pkg::DivStages];

  assign dist_sum = ckas_pkg::SumW'(sq_blue_q) + ckas_pkg::SumW'(sq_green_q) +
                    ckas_pkg::SumW'(sq_red_q);
  assign dist_fx  = ckas_pkg::ThrW'({dist_sum, 16'h0000});
  assign at_inner = dist_fx <= thr_in_q;
  assign at_outer = dist_fx >= thr_out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[ckas_pkg::StgCmp].blue   <= pix_q[ckas_pkg::StgSq].blue;
      pix_q[ckas_pkg::StgCmp].green  <= pix_q[ckas_pkg::StgSq].green;
      pix_q[ckas_pkg::StgCmp].red    <= pix_q[ckas_pkg::StgSq].red;
      pix_q[ckas_pkg::StgCmp].eof    <= pix_q[ckas_pkg::StgSq].eof;
      pix_q[ckas_pkg::StgCmp].ramp   <= !at_inner && !at_outer;
      pix_q[ckas_pkg::StgCmp].opaque <= !at_inner && at_outer;
      // numerator of the ramp fraction, meaningful only inside the ramp
      rem_q[0] <= dist_fx - thr_in_q;
      quo_q[0] <= '0;
    end
  end

  // -------------------------------------------------------------------------
  // stages 3..10: restoring divider, two quotient bits per stage
  // -------------------------------------------------------------------------
  for (genvar k = 1; k <= ckas_pkg::DivStages; k++) begin : g_div
    logic [ckas_pkg::ThrW-1:0]  rem_d;
    logic [ckas_pkg::FracW-1:0] quo_d;

    always_comb begin
      logic [ckas_pkg::ThrW:0] trial;
      rem_d = rem_q[k-1];
      quo_d = quo_q[k-1];
      for (int i = 0; i < ckas_pkg::DivBits; i++) begin
        trial = {rem_d, 1'b0};
        if (trial >= {1'b0, thr_diff_q}) begin
          trial = trial - {1'b0, thr_diff_q};
          quo_d = {quo_d[ckas_pkg::FracW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[ckas_pkg::FracW-2:0], 1'b0};
        end
        rem_d = trial[ckas_pkg::ThrW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage 11: 8-bit alpha, spill weight and pull direction
  // -------------------------------------------------------------------------
  logic [ckas_pkg::FracW-1:0]   ramp_a;
  logic [24:0]                  alpha_scaled;
  logic [ckas_pkg::FracW:0]     inv_a;
  logic [ckas_pkg::ChanW-1:0]   avg;
  logic [ckas_pkg::ChanW:0]     br_sum;
  ckas_pkg::pix_t               pix_div;
  logic [ckas_pkg::ChanW-1:0]   alpha11_q, alpha12_q, alpha13_q;
  logic [ckas_pkg::WeightW-1:0] weight_q;
  logic [ckas_pkg::ChanW-1:0]   gap_q;
  logic                         pull_down11_q, pull_down12_q;

  assign pix_div      = pix_q[ckas_pkg::StgDivLast];
  assign ramp_a       = quo_q[ckas_pkg::DivStages];
  // a * 255 + half, rounded to 8 bits
  assign alpha_scaled = 25'({ramp_a, 8'h00}) - 25'(ramp_a) + 25'd32768;
  assign inv_a        = 17'h10000 - 17'(ramp_a);
  assign br_sum       = 9'(pix_div.blue) + 9'(pix_div.red);
  assign avg          = br_sum[ckas_pkg::ChanW:1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pix_div.ramp) alpha11_q <= alpha_scaled[23:16];
      else if (pix_div.opaque) alpha11_q <= 8'hff;
      else alpha11_q <= 8'h00;
      weight_q      <= ckas_pkg::WeightW'(spill_q) * ckas_pkg::WeightW'(inv_a);
      pull_down11_q <= avg < pix_div.green;
      gap_q         <= (avg < pix_div.green) ? pix_div.green - avg : avg - pix_div.green;
    end
  end

  // -------------------------------------------------------------------------
  // stage 12: spill correction magnitude, never more than the gap
  // -------------------------------------------------------------------------
  logic [40:0]                mag_full;
  logic [ckas_pkg::ChanW-1:0] mag_q;

  assign mag_full = 41'(gap_q) * 41'(weight_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q         <= mag_full[39:32];
      alpha12_q     <= alpha11_q;
      pull_down12_q <= pull_down11_q;
    end
  end

  // -------------------------------------------------------------------------
  // stage 13: output register, green corrected only inside the ramp
  // -------------------------------------------------------------------------
  ckas_pkg::pix_t             pix_mag;
  logic [ckas_pkg::ChanW-1:0] green13_q;

  assign pix_mag = pix_q[ckas_pkg::StgMag];

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha13_q <= alpha12_q;
      if (!pix_mag.ramp) green13_q <= pix_mag.green;
      else if (pull_down12_q) green13_q <= pix_mag.green - mag_q;
      else green13_q <= pix_mag.green + mag_q;
    end
  end

  assign out_valid_o     = v_q[ckas_pkg::StgOut];
  assign blue_out_o      = pix_q[ckas_pkg::StgOut].blue;
  assign green_out_o     = green13_q;
  assign red_out_o       = pix_q[ckas_pkg::StgOut].red;
  assign alpha_out_o     = alpha13_q;
  assign frame_end_out_o = pix_q[ckas_pkg::StgOut].eof;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `CKAS_ASSERT_NEXT(a_reload_blocks_input, thr_reload && thr_state_q == THR_IDLE, !in_ready_o, "input taken during threshold reload")
  `CKAS_ASSERT_NOW(a_thr_consistent, thr_state_q == THR_IDLE, thr_out_q > thr_in_q && thr_diff_q == thr_out_q - thr_in_q, "thresholds out of order")
  `CKAS_ASSERT_NOW(a_div_rem_bound, v_q[ckas_pkg::StgDivLast] && pix_q[ckas_pkg::StgDivLast].ramp, rem_q[ckas_pkg::DivStages] < thr_diff_q, "divider remainder not below ramp width")
  `CKAS_ASSERT_NOW(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o, "input taken while output stalled")

endmodule

@@ sim/chroma_key_alpha_spill_tb.sv @@
// ---------------------------------------------------------------------------
// chroma keyer testbench
// drives bgr pixel requests through the keyer under random idling on both
// channels and checks every keyed pixel against a bit-exact predictor or hand-written values
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module chroma_key_alpha_spill_tb;

  // run shape
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseItems  = 194;
  localparam int unsigned StallPhase  = 2;
  localparam int unsigned StallItem   = 40;
  localparam int unsigned SteadyPhase = 5;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned IdlePct     = 29;
  // pipeline is 13 deep, leave some margin for stray results
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned CycleLimit  = 200000;

  // register indexes with no register behind them
  localparam logic [ckas_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [ckas_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  // one keyed pixel as it leaves the block
  typedef struct packed {
    logic [ckas_pkg::ChanW-1:0] blue;
    logic [ckas_pkg::ChanW-1:0] green;
    logic [ckas_pkg::ChanW-1:0] red;
    logic [ckas_pkg::ChanW-1:0] alpha;
    logic                       eof;
  } keyed_pix_t;

  // one line of stimulus: either a register write or a pixel, where a pixel
  // may carry a hand-written green and alpha
  typedef struct packed {
    logic                          wr;
    logic [ckas_pkg::CfgIdxW-1:0]  idx;
    logic [ckas_pkg::CfgDataW-1:0] data;
    logic [ckas_pkg::ChanW-1:0]    blue;
    logic [ckas_pkg::ChanW-1:0]    green;
    logic [ckas_pkg::ChanW-1:0]    red;
    logic                          eof;
    logic                          typed;
    logic [ckas_pkg::ChanW-1:0]    green_exp;
    logic [ckas_pkg::ChanW-1:0]    alpha_exp;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ckas_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ckas_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [ckas_pkg::ChanW-1:0]    blue_in_i;
  logic [ckas_pkg::ChanW-1:0]    green_in_i;
  logic [ckas_pkg::ChanW-1:0]    red_in_i;
  logic                          end_of_frame_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [ckas_pkg::ChanW-1:0]    blue_out_o;
  logic [ckas_pkg::ChanW-1:0]    green_out_o;
  logic [ckas_pkg::ChanW-1:0]    red_out_o;
  logic [ckas_pkg::ChanW-1:0]    alpha_out_o;
  logic                          frame_end_out_o;

  // keyed pixels still owed by the block, oldest first
  keyed_pix_t keyed_pix_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // shared between sender and receiver: no idling, and the one long hold-off
  bit steady = 1'b0;
  bit hold_trig = 1'b0;

  // predictor copy of the register file and the derived thresholds (q.16)
  logic [ckas_pkg::ChanW-1:0] key_b, key_g, key_r;
  logic [ckas_pkg::FracW-1:0] sim_frac, smooth_frac, spill_frac;
  logic [63:0]                thr_inner, thr_outer;

  always #10 clk_i = ~clk_i;

  chroma_key_alpha_spill uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .blue_in_i       (blue_in_i),
    .green_in_i      (green_in_i),
    .red_in_i        (red_in_i),
    .end_of_frame_i  (end_of_frame_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blue_out_o      (blue_out_o),
    .green_out_o     (green_out_o),
    .red_out_o       (red_out_o),
    .alpha_out_o     (alpha_out_o),
    .frame_end_out_o (frame_end_out_o)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // radius fraction squared, scaled to the full rgb cube, in q.16
  function automatic logic [63:0] cube_dist(input logic [63:0] radius);
    return (radius * radius * 64'(ckas_pkg::MaxDist) + 64'd32768) >> 16;
  endfunction

  function automatic void retune_thresholds();
    thr_inner = cube_dist(64'(sim_frac));
    thr_outer = cube_dist(64'(sim_frac) + 64'(smooth_frac));
  endfunction

  function automatic void mirror_reset();
    key_b       = ckas_pkg::KeyBlueRst;
    key_g       = ckas_pkg::KeyGreenRst;
    key_r       = ckas_pkg::KeyRedRst;
    sim_frac    = ckas_pkg::SimRst;
    smooth_frac = ckas_pkg::SmoothRst;
    spill_frac  = ckas_pkg::SpillRst;
    retune_thresholds();
  endfunction

  // alpha from the distance to the key, and green pulled toward the
  // blue/red average inside the ramp only
  function automatic keyed_pix_t key_pixel(input logic [ckas_pkg::ChanW-1:0] b, g, r,
                                           input logic eof);
    keyed_pix_t  res;
    logic [63:0] db, dg, dr, dist_fx, ramp, wgt, avg, mag;
    db      = (b > key_b) ? 64'(b - key_b) : 64'(key_b - b);
    dg      = (g > key_g) ? 64'(g - key_g) : 64'(key_g - g);
    dr      = (r > key_r) ? 64'(r - key_r) : 64'(key_r - r);
    dist_fx = (db * db + dg * dg + dr * dr) << 16;
    res     = '{blue: b, green: g, red: r, alpha: '0, eof: eof};
    if (dist_fx <= thr_inner) begin
      res.alpha = '0;
    end else if (dist_fx >= thr_outer) begin
      res.alpha = 8'd255;
    end else begin
      // a ramp position of zero still counts as inside the ramp
      ramp      = ((dist_fx - thr_inner) << 16) / (thr_outer - thr_inner);
      res.alpha = 8'((ramp * 64'd255 + 64'd32768) >> 16);
      avg       = (64'(b) + 64'(r)) >> 1;
      wgt       = 64'(spill_frac) * (64'd65536 - ramp);
      if (avg >= 64'(g)) begin
        mag       = ((avg - 64'(g)) * wgt) >> 32;
        res.green = g + 8'(mag);
      end else begin
        mag       = ((64'(g) - avg) * wgt) >> 32;
        res.green = g - 8'(mag);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus rows
  // ---------------------------------------------------------------------------

  function automatic stim_row_t pixel_row(input logic [ckas_pkg::ChanW-1:0] b, g, r,
                                          input logic eof);
    stim_row_t row;
    row       = '0;
    row.blue  = b;
    row.green = g;
    row.red   = r;
    row.eof   = eof;
    return row;
  endfunction

  // pixel whose green and alpha are obvious from the setting
  function automatic stim_row_t known_row(input logic [ckas_pkg::ChanW-1:0] b, g, r,
                                          input logic eof,
                                          input logic [ckas_pkg::ChanW-1:0] g_exp, a_exp);
    stim_row_t row;
    row           = pixel_row(b, g, r, eof);
    row.typed     = 1'b1;
    row.green_exp = g_exp;
    row.alpha_exp = a_exp;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [ckas_pkg::CfgIdxW-1:0] idx,
                                        input logic [ckas_pkg::CfgDataW-1:0] data);
    stim_row_t row;
    row      = '0;
    row.wr   = 1'b1;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // channel value within a random distance of the key, clamped to a byte
  function automatic logic [ckas_pkg::ChanW-1:0] near_chan(
    input logic [ckas_pkg::ChanW-1:0] center,
    input int unsigned spread);
    int v;
    int off;
    off = int'($urandom_range(spread, 0));
    v   = $urandom_range(1, 0) ? int'(center) + off : int'(center) - off;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ckas_pkg::ChanW'(v);
  endfunction

  function automatic logic [ckas_pkg::CfgDataW-1:0] pick_frac(input int unsigned top);
    case ($urandom_range(4, 0))
      0:       return '0;
      1:       return '1;
      default: return ckas_pkg::CfgDataW'($urandom_range(top, 0));
    endcase
  endfunction

  function automatic logic [ckas_pkg::CfgDataW-1:0] pick_key();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return ckas_pkg::CfgDataW'(255);
      // upper byte is random and must be dropped by the block
      default: return ckas_pkg::CfgDataW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // register write, taken at the next rising edge
  task automatic write_reg(input logic [ckas_pkg::CfgIdxW-1:0] idx,
                           input logic [ckas_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      ckas_pkg::REG_KEY_BLUE:   key_b = data[ckas_pkg::ChanW-1:0];
      ckas_pkg::REG_KEY_GREEN:  key_g = data[ckas_pkg::ChanW-1:0];
      ckas_pkg::REG_KEY_RED:    key_r = data[ckas_pkg::ChanW-1:0];
      ckas_pkg::REG_SIMILARITY: begin
        sim_frac = data;
        retune_thresholds();
      end
      ckas_pkg::REG_SMOOTHNESS: begin
        // tiny ramp widths saturate to the minimum
        smooth_frac = (data < ckas_pkg::SmoothMin) ? ckas_pkg::SmoothMin : data;
        retune_thresholds();
      end
      ckas_pkg::REG_SPILL:      spill_frac = data;
      default:                  ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one pixel request; valid stays up after acceptance until the next call
  // either idles or replaces the payload
  task automatic send_pixel(input stim_row_t row);
    keyed_pix_t want;
    @(negedge clk_i);
    while (!steady && $urandom_range(99, 0) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    blue_in_i      <= row.blue;
    green_in_i     <= row.green;
    red_in_i       <= row.red;
    end_of_frame_i <= row.eof;
    do @(posedge clk_i); while (!in_ready_o);
    if (row.typed)
      want = '{blue: row.blue, green: row.green_exp, red: row.red,
               alpha: row.alpha_exp, eof: row.eof};
    else
      want = key_pixel(row.blue, row.green, row.red, row.eof);
    keyed_pix_q.push_back(want);
  endtask

  // stop offering and wait until every owed pixel is back, so the block is
  // idle before a register write
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (keyed_pix_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    stim_row_t                  dir_tbl [$];
    stim_row_t                  row;
    int unsigned                sel;
    int unsigned                spread;
    logic [ckas_pkg::ChanW-1:0] pb, pg, pr;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    blue_in_i      <= '0;
    green_in_i     <= '0;
    red_in_i       <= '0;
    end_of_frame_i <= 1'b0;
    mirror_reset();

    // reset setting: pure green key, similarity 0.4, smoothness 0.1, no spill
    dir_tbl = '{
      // the key itself is fully transparent
      known_row(8'd0, 8'd255, 8'd0, 1'b0, 8'd255, 8'd0),
      // far corners of the cube are fully opaque, green untouched
      known_row(8'd255, 8'd0, 8'd255, 1'b1, 8'd0, 8'd255),
      known_row(8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd255),
      known_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255),
      // one pixel inside the ramp, one inside the inner radius, spill still off
      pixel_row(8'd114, 8'd141, 8'd114, 1'b0),
      pixel_row(8'd100, 8'd200, 8'd60, 1'b0),
      // full spill: green pulled down toward the average
      reg_row(ckas_pkg::REG_SPILL, 16'hFFFF),
      pixel_row(8'd114, 8'd141, 8'd114, 1'b1),
      // black key: green pulled up toward the average
      reg_row(ckas_pkg::REG_KEY_GREEN, 16'h0000),
      pixel_row(8'd120, 8'd40, 8'd130, 1'b0),
      // upper data bits of the key registers are dropped
      reg_row(ckas_pkg::REG_KEY_BLUE, 16'h12FF),
      reg_row(ckas_pkg::REG_KEY_RED, 16'hAB80),
      known_row(8'd255, 8'd0, 8'd128, 1'b1, 8'd0, 8'd0),
      // zero similarity, smoothness below the floor saturates
      reg_row(ckas_pkg::REG_SIMILARITY, 16'h0000),
      reg_row(ckas_pkg::REG_SMOOTHNESS, 16'h0000),
      known_row(8'd255, 8'd0, 8'd128, 1'b0, 8'd0, 8'd0),
      pixel_row(8'd254, 8'd0, 8'd128, 1'b0),
      // widest ramp: one step off the key lands at ramp zero, spill at full
      reg_row(ckas_pkg::REG_SMOOTHNESS, 16'hFFFF),
      pixel_row(8'd255, 8'd1, 8'd128, 1'b1),
      // largest similarity: outer edge lies past the cube, never opaque
      reg_row(ckas_pkg::REG_SIMILARITY, 16'hFFFF),
      reg_row(ckas_pkg::REG_KEY_BLUE, 16'h0000),
      reg_row(ckas_pkg::REG_KEY_RED, 16'h0000),
      pixel_row(8'd255, 8'd255, 8'd255, 1'b0),
      // writes to spare indexes change nothing
      reg_row(RegSpareLo, 16'hFFFF),
      reg_row(RegSpareHi, 16'hFFFF),
      pixel_row(8'd255, 8'd255, 8'd255, 1'b1)
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].wr) begin
        drain_pipe();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        send_pixel(dir_tbl[i]);
      end
    end

    // random phases, each under a fresh register setting
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain_pipe();
      write_reg(ckas_pkg::REG_KEY_BLUE, pick_key());
      write_reg(ckas_pkg::REG_KEY_GREEN, pick_key());
      write_reg(ckas_pkg::REG_KEY_RED, pick_key());
      write_reg(ckas_pkg::REG_SIMILARITY, pick_frac(30000));
      write_reg(ckas_pkg::REG_SMOOTHNESS, pick_frac(20000));
      write_reg(ckas_pkg::REG_SPILL, pick_frac(65535));
      if ($urandom_range(3, 0) == 0)
        write_reg($urandom_range(1, 0) ? RegSpareLo : RegSpareHi,
                  ckas_pkg::CfgDataW'($urandom));
      steady = (ph == SteadyPhase);

      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (ph == StallPhase && n == StallItem) hold_trig = 1'b1;
        sel = $urandom_range(99, 0);
        if (sel < 65) begin
          // mostly around the key, where the ramp and the spill live
          spread = $urandom_range(255, 1);
          pb = near_chan(key_b, spread);
          pg = near_chan(key_g, spread);
          pr = near_chan(key_r, spread);
        end else if (sel < 90) begin
          pb = ckas_pkg::ChanW'($urandom);
          pg = ckas_pkg::ChanW'($urandom);
          pr = ckas_pkg::ChanW'($urandom);
        end else begin
          // cube corners
          pb = {ckas_pkg::ChanW{$urandom_range(1, 0) == 1}};
          pg = {ckas_pkg::ChanW{$urandom_range(1, 0) == 1}};
          pr = {ckas_pkg::ChanW{$urandom_range(1, 0) == 1}};
        end
        row = pixel_row(pb, pg, pr, $urandom_range(99, 0) < 6);
        send_pixel(row);
      end
    end

    drain_pipe();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure, one long hold-off that fills the pipe
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_trig && !hold_used) begin
        hold_left = HoldCycles;
        hold_used = 1'b1;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= steady || ($urandom_range(99, 0) >= IdlePct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest owed pixel
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    keyed_pix_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (keyed_pix_q.size() == 0) begin
        $error("keyed pixel with no request outstanding");
        mismatch_cnt++;
      end else begin
        want = keyed_pix_q.pop_front();
        if (blue_out_o !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, blue_out_o);
          mismatch_cnt++;
        end
        if (green_out_o !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, green_out_o);
          mismatch_cnt++;
        end
        if (red_out_o !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, red_out_o);
          mismatch_cnt++;
        end
        if (alpha_out_o !== want.alpha) begin
          $error("alpha_out: expected %0d, got %0d", want.alpha, alpha_out_o);
          mismatch_cnt++;
        end
        if (frame_end_out_o !== want.eof) begin
          $error("frame_end_out: expected %0d, got %0d", want.eof, frame_end_out_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
